>>> src/ppu_pkg.sv
package ppu_pkg;

  // field widths fixed by the interface
  localparam int RANK_W     = 32;
  localparam int SYM_W      = 8;
  localparam int IDX_W      = 4;
  localparam int BASE_W     = 5;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int NIB_W      = 4;
  localparam int NUM_NIBS   = RANK_W / NIB_W;
  localparam int ALPHA_SIZE = 16;

  localparam int MAX_BASE_DEF = 16;
  localparam int MIN_BASE     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HI  = 3'd3;

  // quotient nibble handed from one digit cell to the next
  typedef struct packed {
    logic             vld;
    logic [NIB_W-1:0] nib;
  } ppu_qbeat_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic              start;
    logic              emit;
    logic [BASE_W-1:0] base;
    logic [IDX_W-1:0]  sel_pick;
    logic [IDX_W-1:0]  sel_last;
    logic [IDX_W-1:0]  last_val;
  } ppu_cell_ctl_t;

  // per-cell values for the working-set lookup
  typedef struct packed {
    logic [IDX_W-1:0] pick_val;
    logic [IDX_W-1:0] last_val;
  } ppu_cell_sts_t;

endpackage

>>> src/ppu_in_if.sv
interface ppu_in_if;
  logic                       valid;
  logic                       ready;
  logic [ppu_pkg::RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

>>> src/ppu_out_if.sv
interface ppu_out_if;
  logic                      valid;
  logic                      ready;
  logic [ppu_pkg::SYM_W-1:0] symbol;
  logic [ppu_pkg::IDX_W-1:0] element_index;
  logic                      last_symbol;

  modport source (output valid, output symbol, output element_index, output last_symbol,
                  input ready);
  modport sink   (input valid, input symbol, input element_index, input last_symbol,
                  output ready);
endinterface

>>> src/ppu_cell.sv
module ppu_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ppu_pkg::ppu_cell_ctl_t       ctl,
  input  ppu_pkg::ppu_qbeat_t          q_in,
  output ppu_pkg::ppu_qbeat_t          q_out,
  input  logic [ppu_pkg::IDX_W-1:0]    rem_in,
  output logic [ppu_pkg::IDX_W-1:0]    rem_out,
  output ppu_pkg::ppu_cell_sts_t       sts
);
  import ppu_pkg::*;

  localparam logic [IDX_W-1:0]  MY_IDX = IDX_W'(IDX);
  localparam logic [BASE_W-1:0] MY_OFS = BASE_W'(IDX);

  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic              vld_r, vld_nxt;
  logic [NIB_W-1:0]  q_r, q_nxt;
  logic [BASE_W-1:0] div;
  logic [BASE_W-1:0] part;
  logic [NIB_W-1:0]  qd;
  logic              pick_hit;
  logic              last_hit;

  // divisor of this digit position
  assign div = ctl.base - MY_OFS;

  // radix-16 long-division step, one quotient bit per restoring step
  always_comb begin
    part = {1'b0, rem_r};
    qd   = '0;
    for (int k = NIB_W - 1; k >= 0; k--) begin
      part = {part[BASE_W-2:0], q_in.nib[k]};
      if (part >= div) begin
        part  = part - div;
        qd[k] = 1'b1;
      end
    end
  end

  // remainder: cleared on start, shifted toward cell zero while emitting, else updated by each division step
  always_comb begin
    rem_nxt = rem_r;
    if (ctl.start) begin
      rem_nxt = '0;
    end else if (ctl.emit) begin
      rem_nxt = rem_in;
    end else if (q_in.vld) begin
      rem_nxt = part[IDX_W-1:0];
    end
  end

  // quotient beat to the next digit
  always_comb begin
    vld_nxt = q_in.vld && !ctl.start;
    q_nxt   = q_in.vld ? qd : q_r;
  end

  // working-set slot, last slot moves into the picked one
  assign pick_hit = (ctl.sel_pick == MY_IDX);
  assign last_hit = (ctl.sel_last == MY_IDX);

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.start) begin
      slot_nxt = MY_IDX;
    end else if (ctl.emit && pick_hit) begin
      slot_nxt = ctl.last_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    rem_r  <= rem_nxt;
    slot_r <= slot_nxt;
    q_r    <= q_nxt;
  end

  assign q_out.vld    = vld_r;
  assign q_out.nib    = q_r;
  assign rem_out      = rem_r;
  assign sts.pick_val = pick_hit ? slot_r : '0;
  assign sts.last_val = last_hit ? slot_r : '0;

endmodule

>>> src/partial_permutation_unrank.sv
// Partial permutation unranker.
// in_ch carries one 32-bit rank per beat; out_ch returns pick_count (clamped)
// beats per rank, each with the chosen alphabet symbol, its original alphabet
// position and last_symbol set on the final beat of the rank. Configuration
// must be written through cfg_we / cfg_index / cfg_wdata while the block is
// idle; the block itself does not enforce this. A rank is taken from in_ch,
// then a row of MAX_BASE digit cells divides it: each cell divides the
// quotient stream of its neighbor (the rank for cell zero) by its own base,
// one nibble a cycle. The digits are then sent one beat a cycle while out_ch
// is ready; the next rank is taken while the final beat of the previous one
// still waits in the output register.
// A stalled receiver holds the output register and stops the emission; no
// beat is lost. Reset (rst_n low, synchronous) empties the block and sets
// radix_base to 16, pick_count to 1 and the alphabet to all zero bytes.
module partial_permutation_unrank #(
  parameter int MAX_BASE = ppu_pkg::MAX_BASE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ppu_in_if.sink                         in_ch,
  ppu_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppu_pkg::CFG_W-1:0]      cfg_wdata
);
  import ppu_pkg::*;

  localparam int CNT_W = $clog2(NUM_NIBS + MAX_BASE);

  typedef enum logic [1:0] {S_IDLE, S_COMP, S_EMIT} state_t;

  state_t               state_r;
  logic [BASE_W-1:0]    radix_base_r;
  logic [BASE_W-1:0]    pick_count_r;
  logic [CFG_W-1:0]     sym_lo_r;
  logic [CFG_W-1:0]     sym_hi_r;
  logic [BASE_W-1:0]    base_r;
  logic [BASE_W-1:0]    len_r;
  logic [RANK_W-1:0]    rank_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     dig_r;
  logic                 out_vld_r;
  logic [SYM_W-1:0]     out_sym_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic                 out_last_r;

  logic [BASE_W-1:0]    base_clamp;
  logic [BASE_W-1:0]    len_clamp;
  logic                 in_acc;
  logic                 emit_go;
  logic                 dig_last;
  logic [BASE_W-1:0]    b_cur;
  logic [IDX_W-1:0]     pick_pos;
  logic [IDX_W-1:0]     last_pos;
  logic [2*CFG_W-1:0]   alphabet;
  ppu_cell_ctl_t        ctl;
  ppu_qbeat_t           feed;
  ppu_qbeat_t           q_w   [MAX_BASE];
  logic [IDX_W-1:0]     rem_w [MAX_BASE];
  ppu_cell_sts_t        sts_w [MAX_BASE];

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_base_r <= BASE_W'(ALPHA_SIZE);
      pick_count_r <= BASE_W'(1);
      sym_lo_r     <= '0;
      sym_hi_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX_BASE:  radix_base_r <= cfg_wdata[BASE_W-1:0];
        REG_PICK_COUNT:  pick_count_r <= cfg_wdata[BASE_W-1:0];
        REG_SYMBOLS_LOW: sym_lo_r     <= cfg_wdata;
        REG_SYMBOLS_HI:  sym_hi_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp base to 2..MAX_BASE and pick count to 1..base
  always_comb begin
    base_clamp = radix_base_r;
    if (radix_base_r < BASE_W'(MIN_BASE)) begin
      base_clamp = BASE_W'(MIN_BASE);
    end else if (radix_base_r > BASE_W'(MAX_BASE)) begin
      base_clamp = BASE_W'(MAX_BASE);
    end
    len_clamp = pick_count_r;
    if (pick_count_r == '0) begin
      len_clamp = BASE_W'(1);
    end else if (pick_count_r > base_clamp) begin
      len_clamp = base_clamp;
    end
  end

  assign in_acc   = in_ch.valid && (state_r == S_IDLE);
  assign emit_go  = (state_r == S_EMIT) && (!out_vld_r || out_ch.ready);
  assign dig_last = ({1'b0, dig_r} == (len_r - BASE_W'(1)));
  assign b_cur    = base_r - {1'b0, dig_r};

  // nibble stream into the first cell, most significant first
  assign feed.vld = (state_r == S_COMP) && (cnt_r < CNT_W'(NUM_NIBS));
  assign feed.nib = rank_r[RANK_W-1 -: NIB_W];

  // broadcast controls
  assign ctl.start    = in_acc;
  assign ctl.emit     = emit_go;
  assign ctl.base     = base_r;
  assign ctl.sel_pick = rem_w[0];
  assign ctl.sel_last = b_cur[IDX_W-1:0] - IDX_W'(1);
  assign ctl.last_val = last_pos;

  // working-set lookup across the cells
  always_comb begin
    pick_pos = '0;
    last_pos = '0;
    for (int j = 0; j < MAX_BASE; j++) begin
      pick_pos = pick_pos | sts_w[j].pick_val;
      last_pos = last_pos | sts_w[j].last_val;
    end
  end

  assign alphabet = {sym_hi_r, sym_lo_r};

  // row of digit cells
  for (genvar d = 0; d < MAX_BASE; d++) begin : g_cell
    ppu_qbeat_t       q_in_d;
    logic [IDX_W-1:0] rem_in_d;

    if (d == 0) begin : g_head
      assign q_in_d = feed;
    end else begin : g_body
      assign q_in_d = q_w[d-1];
    end

    if (d == MAX_BASE - 1) begin : g_tail
      assign rem_in_d = '0;
    end else begin : g_link
      assign rem_in_d = rem_w[d+1];
    end

    ppu_cell #(.IDX(d)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .q_in    (q_in_d),
      .q_out   (q_w[d]),
      .rem_in  (rem_in_d),
      .rem_out (rem_w[d]),
      .sts     (sts_w[d])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      // output beat loaded on emission, dropped once taken
      if (emit_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_COMP;
          end
        end
        S_COMP: begin
          if (cnt_r == CNT_W'(len_r) + CNT_W'(NUM_NIBS - 2)) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go && dig_last) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end

    if (in_acc) begin
      rank_r <= in_ch.rank;
      base_r <= base_clamp;
      len_r  <= len_clamp;
      cnt_r  <= '0;
    end else if (state_r == S_COMP) begin
      rank_r <= rank_r << NIB_W;
      cnt_r  <= cnt_r + CNT_W'(1);
    end

    if (state_r == S_COMP) begin
      dig_r <= '0;
    end else if (emit_go) begin
      dig_r <= dig_r + IDX_W'(1);
    end

    if (emit_go) begin
      out_sym_r  <= alphabet[{pick_pos, 3'b000} +: SYM_W];
      out_idx_r  <= pick_pos;
      out_last_r <= dig_last;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_vld_r;
  assign out_ch.symbol        = out_sym_r;
  assign out_ch.element_index = out_idx_r;
  assign out_ch.last_symbol   = out_last_r;

endmodule

>>> bench/partial_permutation_unrank_tb.sv
module partial_permutation_unrank_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppu_pkg::*;

  localparam int MAX_BASE = MAX_BASE_DEF;
  // register indexes past the last real one, decoded as no-ops
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
  localparam int SPARE_COUNT = 4;
  localparam int MAX_REPORTS = 40;
  localparam int RANDOM_PHASES = 10;
  localparam int RANKS_PER_PHASE = 30;

  // one result beat as the block should send it
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] element_index;
    logic             last_symbol;
  } sym_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  ppu_in_if  in_ch ();
  ppu_out_if out_ch ();

  partial_permutation_unrank i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // local copy of the register file
  logic [BASE_W-1:0] base_cfg;
  logic [BASE_W-1:0] pick_cfg;
  logic [CFG_W-1:0]  alpha_lo;
  logic [CFG_W-1:0]  alpha_hi;

  sym_beat_t pending_symbols[$];

  int err_count;
  int ranks_sent;
  int beats_checked;
  int settings_used;
  int stall_left;
  bit tx_steady;
  bit rx_steady;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // mostly short idle stretches, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // k-permutation of the alphabet for one rank, swap-last working set
  function automatic void predict_symbols(input logic [RANK_W-1:0] rank);
    logic [IDX_W-1:0]        slot [ALPHA_SIZE];
    logic [2*CFG_W-1:0]      alpha;
    logic [RANK_W-1:0]       quot;
    logic [IDX_W-1:0]        pos;
    int unsigned             divisor;
    int unsigned             count;
    int unsigned             digit;
    sym_beat_t               beat;
    divisor = base_cfg;
    if (divisor < MIN_BASE) divisor = MIN_BASE;
    if (divisor > MAX_BASE) divisor = MAX_BASE;
    if (divisor > ALPHA_SIZE) divisor = ALPHA_SIZE;
    count = pick_cfg;
    if (count < 1) count = 1;
    if (count > divisor) count = divisor;
    for (int k = 0; k < ALPHA_SIZE; k++) slot[k] = IDX_W'(k);
    alpha = {alpha_hi, alpha_lo};
    quot = rank;
    for (int unsigned k = 0; k < count; k++) begin
      digit = quot % divisor;
      quot = quot / divisor;
      pos = slot[digit];
      beat.symbol = alpha[SYM_W*pos +: SYM_W];
      beat.element_index = pos;
      beat.last_symbol = (k + 1 == count);
      pending_symbols.push_back(beat);
      divisor--;
      slot[digit] = slot[divisor];
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_beat
    sym_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("beat with no rank pending, symbol %h index %0d",
                                  out_ch.symbol, out_ch.element_index));
      end else begin
        want = pending_symbols.pop_front();
        beats_checked++;
        if (out_ch.symbol !== want.symbol)
          report_mismatch($sformatf("symbol %h, expected %h", out_ch.symbol, want.symbol));
        if (out_ch.element_index !== want.element_index)
          report_mismatch($sformatf("element_index %0d, expected %0d",
                                    out_ch.element_index, want.element_index));
        if (out_ch.last_symbol !== want.last_symbol)
          report_mismatch($sformatf("last_symbol %b, expected %b",
                                    out_ch.last_symbol, want.last_symbol));
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap() - 1;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    case (index)
      REG_RADIX_BASE:  base_cfg = data[BASE_W-1:0];
      REG_PICK_COUNT:  pick_cfg = data[BASE_W-1:0];
      REG_SYMBOLS_LOW: alpha_lo = data;
      REG_SYMBOLS_HI:  alpha_hi = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] pick,
                               input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    write_reg(REG_RADIX_BASE, base);
    write_reg(REG_PICK_COUNT, pick);
    write_reg(REG_SYMBOLS_LOW, lo);
    write_reg(REG_SYMBOLS_HI, hi);
    settings_used++;
  endtask

  // one rank beat; valid stays high so back-to-back ranks need no gap
  task automatic send_rank(input logic [RANK_W-1:0] rank);
    int gap;
    gap = (!tx_steady && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.rank = rank;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_symbols(rank);
    ranks_sent++;
  endtask

  // stop sending and let every pending symbol drain
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register values straight out of reset
  task automatic test_reset_values();
    send_rank('0);
    send_rank('1);
    send_rank(32'd7);
    wait_idle();
  endtask

  // full 16-of-16 pick over a printable alphabet, extreme ranks
  task automatic test_full_pick();
    apply_setting(64'd16, 64'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_rank('0);
    send_rank('1);
    send_rank(32'h1234_5678);
    send_rank(32'h8000_0001);
    wait_idle();
  endtask

  // base below two and above max, pick of zero and above base
  task automatic test_clamping();
    apply_setting(64'd0, 64'd0, 64'hF0E1_D2C3_B4A5_9687, 64'h7869_5A4B_3C2D_1E0F);
    send_rank('0);
    send_rank(32'd3);
    wait_idle();
    apply_setting(64'd1, 64'd5, alpha_lo, alpha_hi);
    send_rank(32'd2);
    wait_idle();
    apply_setting(64'd17, 64'd16, alpha_lo, alpha_hi);
    send_rank('1);
    wait_idle();
    apply_setting(64'd31, 64'd31, alpha_lo, alpha_hi);
    send_rank(32'hDEAD_BEEF);
    wait_idle();
    apply_setting(64'd4, 64'd9, alpha_lo, alpha_hi);
    send_rank(32'd23);
    send_rank('1);
    wait_idle();
    apply_setting(64'd2, 64'd2, alpha_lo, alpha_hi);
    send_rank(32'd1);
    wait_idle();
  endtask

  // writes to unused indexes must leave every register alone
  task automatic test_spare_index();
    for (int k = 0; k < SPARE_COUNT; k++)
      write_reg(REG_SPARE_FIRST + CFG_IDX_W'(k), {$urandom, 27'($urandom), 5'd9});
    send_rank(32'h0000_0005);
    send_rank(32'hA5A5_5A5A);
    wait_idle();
  endtask

  // random settings and ranks under random flow control
  task automatic test_random();
    logic [CFG_W-1:0]  base;
    logic [CFG_W-1:0]  pick;
    logic [RANK_W-1:0] rank;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      base = {$urandom, $urandom};
      pick = {$urandom, $urandom};
      if (p == 0) begin
        base[BASE_W-1:0] = BASE_W'(MIN_BASE);
        pick[BASE_W-1:0] = BASE_W'(MIN_BASE);
      end else if (p == 1) begin
        base[BASE_W-1:0] = BASE_W'(MAX_BASE);
        pick[BASE_W-1:0] = BASE_W'(MAX_BASE);
      end else begin
        base[BASE_W-1:0] = ($urandom_range(0, 9) < 7) ? BASE_W'($urandom_range(2, 16))
                                                     : BASE_W'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: pick[BASE_W-1:0] = BASE_W'($urandom_range(1, 16));
          5, 6:          pick[BASE_W-1:0] = base[BASE_W-1:0];
          default:       pick[BASE_W-1:0] = BASE_W'($urandom);
        endcase
      end
      apply_setting(base, pick, {$urandom, $urandom}, {$urandom, $urandom});
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < RANKS_PER_PHASE; k++) begin
        case ($urandom_range(0, 3))
          0:       rank = RANK_W'($urandom_range(0, 255));
          default: rank = $urandom;
        endcase
        send_rank(rank);
      end
      wait_idle();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rank = '0;
    out_ch.ready = 1'b0;
    stall_left = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    base_cfg = BASE_W'(16);
    pick_cfg = BASE_W'(1);
    alpha_lo = '0;
    alpha_hi = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_full_pick();
    test_clamping();
    test_spare_index();
    test_random();

    wait_idle();
    repeat (60) @(posedge clk);
    $display("checked %0d symbol beats from %0d ranks over %0d register settings",
             beats_checked, ranks_sent, settings_used);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> partial_permutation_unrank.f
src/ppu_pkg.sv
src/ppu_in_if.sv
src/ppu_out_if.sv
src/ppu_cell.sv
src/partial_permutation_unrank.sv
bench/partial_permutation_unrank_tb.sv
